// File: rtl/bdsr_pkg.sv
// bdsr_pkg: request and response types, opcode and read kind codes,
// address constants and card state struct for the banked dsr grom port
// no dependencies
`timescale 1ns / 1ps

package bdsr_pkg;

  // opcodes of one bus access
  localparam logic [1:0] OP_CRU_WRITE = 2'd0;
  localparam logic [1:0] OP_WIN_WRITE = 2'd1;
  localparam logic [1:0] OP_WIN_READ  = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  // read kinds of one response
  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_BYTE      = 2'd1;
  localparam logic [1:0] KIND_FETCH     = 2'd2;
  localparam logic [1:0] KIND_UNCLAIMED = 2'd3;

  localparam logic [15:0] ADDR_WRITE_PORT = 16'h5FFE;
  localparam logic [15:0] DATA_READ_PORT  = 16'h5BFC;
  localparam logic [15:0] ADDR_READ_PORT  = 16'h5BFE;
  localparam logic [6:0]  CRU_ENABLE_OFS  = 7'h00;
  localparam logic [6:0]  CRU_BANK_OFS    = 7'h40;
  localparam logic [2:0]  WINDOW_TOP      = 3'b010;
  localparam logic [7:0]  HIDDEN_BYTE     = 8'hFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  read_kind;
    logic [7:0]  read_byte;
    logic [16:0] fetch_offset;
    logic        window_visible;
    logic        selected_bank;
  } rsp_t;

  typedef struct packed {
    logic        visible;
    logic        bank_select;
    logic [15:0] grom_address;
    logic        write_low_next;
    logic        read_low_next;
  } card_state_t;

endpackage

// File: rtl/bdsr_decode.sv
// bdsr_decode: combinational decode of one bus access against the card state,
// gives the response and the next card state
// depends on bdsr_pkg
`timescale 1ns / 1ps

module bdsr_decode import bdsr_pkg::*; (
  input  req_t        req,
  input  card_state_t state,
  input  logic        card_enabled,
  output rsp_t        rsp,
  output card_state_t state_next
);

  logic [15:0] addr_plus;
  logic [15:0] bumped;
  logic        in_window;

  assign addr_plus = state.grom_address + 16'd1;
  assign bumped    = {state.grom_address[15:13], addr_plus[12:0]};
  assign in_window = (req.bus_address[15:13] == WINDOW_TOP);

  always_comb begin
    state_next       = state;
    rsp.read_kind    = KIND_NONE;
    rsp.read_byte    = 8'd0;
    rsp.fetch_offset = 17'd0;
    case (req.opcode)
      OP_CRU_WRITE: begin
        if (card_enabled) begin
          if (req.bus_address[6:0] == CRU_ENABLE_OFS) begin
            state_next.visible = (req.write_data != 8'd0);
          end else if (req.bus_address[6:0] == CRU_BANK_OFS) begin
            state_next.bank_select = req.write_data[0];
          end
        end
      end
      OP_WIN_WRITE: begin
        if (state.visible && req.bus_address == ADDR_WRITE_PORT) begin
          state_next.read_low_next = 1'b0;
          if (state.write_low_next) begin
            state_next.grom_address   = {state.grom_address[15:8], req.write_data};
            state_next.write_low_next = 1'b0;
          end else begin
            state_next.grom_address   = {req.write_data, state.grom_address[7:0]};
            state_next.write_low_next = 1'b1;
          end
        end
      end
      OP_WIN_READ: begin
        if (!in_window) begin
          rsp.read_kind = KIND_UNCLAIMED;
        end else if (!state.visible) begin
          rsp.read_kind = KIND_BYTE;
          rsp.read_byte = HIDDEN_BYTE;
        end else if (req.bus_address == DATA_READ_PORT) begin
          // grom space sits above the 64K of card rom
          rsp.read_kind           = KIND_FETCH;
          rsp.fetch_offset        = {1'b1, state.grom_address};
          state_next.grom_address = bumped;
        end else if (req.bus_address == ADDR_READ_PORT) begin
          rsp.read_kind             = KIND_BYTE;
          state_next.write_low_next = 1'b0;
          if (state.read_low_next) begin
            rsp.read_byte            = addr_plus[7:0];
            state_next.read_low_next = 1'b0;
          end else begin
            rsp.read_byte            = bumped[15:8];
            state_next.read_low_next = 1'b1;
          end
        end else if (!req.bus_address[12]) begin
          // fixed lower 4K bank
          rsp.read_kind    = KIND_FETCH;
          rsp.fetch_offset = {5'd0, req.bus_address[11:0]};
        end else begin
          // switched upper bank: 0x1000 or 0x2000 plus offset
          rsp.read_kind    = KIND_FETCH;
          rsp.fetch_offset = {3'd0, state.bank_select, ~state.bank_select,
                              req.bus_address[11:0]};
        end
      end
      default: begin
      end
    endcase
    rsp.window_visible = state_next.visible;
    rsp.selected_bank  = state_next.bank_select;
  end

endmodule

// File: rtl/banked_dsr_grom_port_unit.sv
// banked_dsr_grom_port_unit: top level of the banked dsr grom port card model,
// request register, card state, response register and config register
// depends on bdsr_pkg and bdsr_decode
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        request    in_valid / in_stall    in_data  (req_t)
// out       response   out_valid / out_stall  out_data (rsp_t)
// cfg       write      cfg_we                 cfg_data (card_enabled)
//
// one request per cycle sustained while out_stall is low; an accepted request goes
// to the request register, then through one pass of decode into the response register
// card state is updated in the same cycle the response register loads
// rst (synchronous) clears card state, config and both valid flags
// out_stall holds the response register; in_stall rises only while the request
// register is full and cannot move into a held response register

module banked_dsr_grom_port_unit import bdsr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data,
  input  logic cfg_we,
  input  logic cfg_data
);

  // request register
  logic        req_valid;
  req_t        req;

  // card state and config
  card_state_t state;
  card_state_t state_next;
  logic        card_enabled;

  rsp_t        rsp_next;
  logic        advance;

  // the request register moves on when the response register is free or drains
  assign advance  = !out_valid || !out_stall;
  assign in_stall = req_valid && !advance;

  bdsr_decode u_decode (
    .req          (req),
    .state        (state),
    .card_enabled (card_enabled),
    .rsp          (rsp_next),
    .state_next   (state_next)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      card_enabled <= 1'b0;
    end else if (cfg_we) begin
      card_enabled <= cfg_data;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= in_data;
    end
  end

  // card state: changes only when a request passes into the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (req_valid && advance) begin
      state <= state_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && advance) begin
      out_data <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // the two byte toggles clear each other, so both are never set
  a_toggles_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(state.write_low_next && state.read_low_next))
    else $error("write and read byte toggles both set");

  // an empty request register never stalls the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !req_valid |-> !in_stall)
    else $error("input stalled with empty request register");

  // an accepted request lands in the request register
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> req_valid)
    else $error("accepted request lost");

  // a byte response from a hidden window is always the hidden byte
  a_hidden_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.read_kind == KIND_BYTE && !out_data.window_visible)
      |-> (out_data.read_byte == HIDDEN_BYTE))
    else $error("hidden window read gave a byte other than 0xFF");
`endif

endmodule
